>>> design/balloc_pkg.sv
// Shared constants, node word layout, status codes, controller states and
// datapath operations of the buddy allocator. No dependencies.
package balloc_pkg;

    localparam int MAX_SIZE_LOG2 = 10;
    localparam int ID_BITS       = 16;
    localparam int NODE_COUNT    = (1 << MAX_SIZE_LOG2) - 1;
    localparam int IDX_W         = MAX_SIZE_LOG2;
    localparam int BYTES_W       = MAX_SIZE_LOG2 + 1;
    localparam int LOG_W         = 4;
    localparam int REQ_W         = 11;
    localparam int STATUS_W      = 3;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam logic [LOG_W-1:0] TOTAL_LOG2_RESET = 4'd10;
    localparam logic [LOG_W-1:0] MIN_LOG2_RESET   = 4'd1;

    typedef enum logic {
        REG_TOTAL_LOG2 = 1'b0,
        REG_MIN_LOG2   = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        MK_ABSENT = 2'd0,
        MK_FREE   = 2'd1,
        MK_SPLIT  = 2'd2,
        MK_ALLOC  = 2'd3
    } t_mark;

    typedef struct packed {
        t_mark                mark;
        logic [BYTES_W-1:0]   lf;
        logic [ID_BITS-1:0]   owner;
    } t_node;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_OVER_CAP  = 3'd2,
        ST_NO_HOLE   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_A_CHK, S_A_TEST, S_A_EVAL, S_A_WL, S_A_WR, S_A_STEP,
        S_A_LOAD, S_A_FINAL, S_U_START, S_U_RDR, S_U_EVAL, S_U_WR, S_U_WP,
        S_F_EVAL, S_F_UP, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR, OP_LOAD, OP_A_CHK, OP_A_TEST, OP_A_EVAL, OP_A_WL,
        OP_A_WR, OP_A_STEP, OP_A_LOAD, OP_A_FINAL, OP_U_RDL, OP_U_RDR,
        OP_U_EVAL, OP_U_WR, OP_U_WP, OP_F_EVAL, OP_F_UP, OP_DONE
    } t_op;

    typedef struct packed {
        logic cfg_clear;
        logic clr_last;
        logic chk_fail;
        logic size_gt_q;
        logic node_free;
        logic hit;
        logic descend;
        logic at_root;
        logic is_odd;
        logic both_free;
        logic out_free;
    } t_flags;

endpackage

>>> design/balloc_ctrl.sv
// Controller state machine of the buddy allocator: sequences the datapath
// one operation per cycle. Depends on balloc_pkg.
module balloc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_func,
    input  balloc_pkg::t_flags  i_flags,
    output logic                o_stall,
    output balloc_pkg::t_op     o_op
);
    import balloc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (i_flags.clr_last) n_state = S_IDLE;
            S_IDLE:    if (i_valid) n_state = i_func ? S_F_EVAL : S_A_CHK;
            S_A_CHK:   n_state = i_flags.chk_fail ? S_DONE : S_A_TEST;
            S_A_TEST:  n_state = i_flags.size_gt_q ? S_A_EVAL : S_A_FINAL;
            S_A_EVAL:  n_state = i_flags.node_free ? S_A_WL : S_A_STEP;
            S_A_WL:    n_state = S_A_WR;
            S_A_WR:    n_state = S_A_STEP;
            S_A_STEP:  n_state = S_A_LOAD;
            S_A_LOAD:  n_state = S_A_TEST;
            S_A_FINAL: n_state = i_flags.node_free ? S_U_START : S_DONE;
            S_U_START: n_state = i_flags.at_root ? S_DONE : S_U_RDR;
            S_U_RDR:   n_state = S_U_EVAL;
            S_U_EVAL:  n_state = i_flags.both_free ? S_U_WR : S_U_START;
            S_U_WR:    n_state = S_U_WP;
            S_U_WP:    n_state = S_U_START;
            S_F_EVAL: begin
                priority if (i_flags.hit) n_state = S_U_START;
                else if (i_flags.descend) n_state = S_F_EVAL;
                else n_state = S_F_UP;
            end
            S_F_UP: begin
                priority if (i_flags.at_root) n_state = S_DONE;
                else if (i_flags.is_odd) n_state = S_F_EVAL;
                else n_state = S_F_UP;
            end
            S_DONE:    if (i_flags.out_free) n_state = S_IDLE;
            default:   n_state = S_CLEAR;
        endcase
        // A new memory size invalidates the whole tree.
        if (i_flags.cfg_clear) n_state = S_CLEAR;
    end

    always_comb begin
        o_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_CLEAR:   o_op = OP_CLR;
            S_IDLE:    o_op = i_valid ? OP_LOAD : OP_NONE;
            S_A_CHK:   o_op = OP_A_CHK;
            S_A_TEST:  o_op = OP_A_TEST;
            S_A_EVAL:  o_op = OP_A_EVAL;
            S_A_WL:    o_op = OP_A_WL;
            S_A_WR:    o_op = OP_A_WR;
            S_A_STEP:  o_op = OP_A_STEP;
            S_A_LOAD:  o_op = OP_A_LOAD;
            S_A_FINAL: o_op = OP_A_FINAL;
            S_U_START: o_op = i_flags.at_root ? OP_NONE : OP_U_RDL;
            S_U_RDR:   o_op = OP_U_RDR;
            S_U_EVAL:  o_op = OP_U_EVAL;
            S_U_WR:    o_op = OP_U_WR;
            S_U_WP:    o_op = OP_U_WP;
            S_F_EVAL:  o_op = OP_F_EVAL;
            S_F_UP:    o_op = OP_F_UP;
            S_DONE:    o_op = OP_DONE;
            default:   o_op = OP_NONE;
        endcase
    end

endmodule

>>> design/balloc_dp.sv
// Datapath of the buddy allocator: node memory, configuration registers,
// tree walk registers and the result register. Depends on balloc_pkg.
module balloc_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  balloc_pkg::t_op                      i_op,
    output balloc_pkg::t_flags                   o_flags,
    input  logic [balloc_pkg::ID_BITS-1:0]       i_owner_id,
    input  logic [balloc_pkg::REQ_W-1:0]         i_request_bytes,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [balloc_pkg::STATUS_W-1:0]      o_status,
    output logic [balloc_pkg::BYTES_W-1:0]       o_start_addr,
    output logic [balloc_pkg::BYTES_W-1:0]       o_block_bytes,
    output logic [balloc_pkg::BYTES_W-1:0]       o_used_bytes,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [balloc_pkg::ADDR_W-1:0]        paddr,
    input  logic [balloc_pkg::DATA_W-1:0]        pwdata,
    output logic [balloc_pkg::DATA_W-1:0]        prdata,
    output logic                                 pready
);
    import balloc_pkg::*;

    t_node                r_mem [NODE_COUNT];
    t_node                r_rd;
    t_node                r_node;
    t_node                r_left;
    logic [LOG_W-1:0]     r_tsz;
    logic [LOG_W-1:0]     r_min;
    logic [BYTES_W-1:0]   r_used;
    logic [IDX_W-1:0]     r_clr_cnt;
    logic [ID_BITS-1:0]   r_id;
    logic [LOG_W-1:0]     r_qlog;
    logic [IDX_W-1:0]     r_idx;
    logic [LOG_W-1:0]     r_depth;
    logic [LOG_W-1:0]     r_lvl;
    logic [BYTES_W-1:0]   r_start;
    logic [BYTES_W-1:0]   r_lf_l;
    t_status              r_res_status;
    logic [BYTES_W-1:0]   r_res_start;
    logic [BYTES_W-1:0]   r_res_bytes;
    logic                 r_out_valid;
    t_status              r_o_status;
    logic [BYTES_W-1:0]   r_o_start;
    logic [BYTES_W-1:0]   r_o_bytes;
    logic [BYTES_W-1:0]   r_o_used;

    logic                 cfg_wr;
    logic [LOG_W-1:0]     tlog;
    logic [BYTES_W:0]     q_val;
    logic [BYTES_W:0]     total_val;
    logic [BYTES_W-1:0]   size_val;
    logic [BYTES_W-1:0]   half_val;
    logic [IDX_W-1:0]     left_idx;
    logic [IDX_W-1:0]     right_idx;
    logic [IDX_W-1:0]     parent_idx;
    logic [IDX_W-1:0]     pos;
    logic [LOG_W-1:0]     req_log;
    logic [LOG_W-1:0]     qlog_in;
    logic                 too_large;
    logic                 over_cap;
    logic                 no_hole;
    logic                 go_left;
    logic                 hit;
    logic                 descend;
    logic                 both_free;
    logic                 out_free;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    t_node                wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;

    function automatic logic [LOG_W-1:0] ceil_log2(input logic [REQ_W-1:0] v);
        logic [LOG_W-1:0] k;
        k = '0;
        for (int i = 0; i <= REQ_W; i++) begin
            if (((REQ_W+1)'(1) << i) < {1'b0, v}) k = LOG_W'(i + 1);
        end
        return k;
    endfunction

    // Configuration port
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (t_reg'(paddr[2]) == REG_MIN_LOG2) ? DATA_W'(r_min) : DATA_W'(r_tsz);

    always_comb begin
        if (r_tsz == '0) tlog = LOG_W'(1);
        else if (r_tsz > LOG_W'(MAX_SIZE_LOG2)) tlog = LOG_W'(MAX_SIZE_LOG2);
        else tlog = r_tsz;
    end

    always_comb begin
        req_log = ceil_log2(i_request_bytes);
        qlog_in = (req_log < LOG_W'(1)) ? LOG_W'(1) : req_log;
        if (qlog_in < r_min) qlog_in = r_min;
    end

    assign q_val      = (BYTES_W+1)'(1) << r_qlog;
    assign total_val  = (BYTES_W+1)'(1) << tlog;
    assign size_val   = BYTES_W'(1) << r_lvl;
    assign half_val   = BYTES_W'(1) << (r_lvl - LOG_W'(1));
    assign left_idx   = IDX_W'({r_idx, 1'b1});
    assign right_idx  = IDX_W'({r_idx, 1'b0}) + IDX_W'(2);
    assign parent_idx = (r_idx - IDX_W'(1)) >> 1;
    assign pos        = r_idx + IDX_W'(1) - (IDX_W'(1) << r_depth);

    assign too_large  = r_qlog > tlog;
    assign over_cap   = ({1'b0, r_used} + q_val) > total_val;
    assign no_hole    = {1'b0, r_rd.lf} < q_val;
    assign go_left    = {1'b0, r_lf_l} >= q_val;
    assign hit        = (r_rd.mark == MK_ALLOC) && (r_rd.owner == r_id);
    assign descend    = (r_rd.mark == MK_SPLIT) && (r_lvl > LOG_W'(1));
    assign both_free  = (r_left.mark == MK_FREE) && (r_rd.mark == MK_FREE);
    assign out_free   = !r_out_valid || !i_stall;

    always_comb begin
        o_flags.cfg_clear = cfg_wr && (t_reg'(paddr[2]) == REG_TOTAL_LOG2);
        o_flags.clr_last  = r_clr_cnt == IDX_W'(NODE_COUNT - 1);
        o_flags.chk_fail  = too_large || over_cap || no_hole;
        o_flags.size_gt_q = r_lvl > r_qlog;
        o_flags.node_free = r_node.mark == MK_FREE;
        o_flags.hit       = hit;
        o_flags.descend   = descend;
        o_flags.at_root   = r_idx == '0;
        o_flags.is_odd    = r_idx[0];
        o_flags.both_free = both_free;
        o_flags.out_free  = out_free;
    end

    // Memory port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = r_idx;
        unique case (i_op)
            OP_CLR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_cnt;
                if (r_clr_cnt == '0) begin
                    wr_data.mark = MK_FREE;
                    wr_data.lf   = total_val[BYTES_W-1:0];
                end
            end
            OP_LOAD: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            OP_A_TEST: begin
                rd_en   = 1'b1;
                rd_addr = left_idx;
            end
            OP_A_EVAL: begin
                if (r_node.mark == MK_FREE) begin
                    wr_en        = 1'b1;
                    wr_data      = r_node;
                    wr_data.mark = MK_SPLIT;
                end
            end
            OP_A_WL, OP_A_WR: begin
                wr_en        = 1'b1;
                wr_addr      = (i_op == OP_A_WL) ? left_idx : right_idx;
                wr_data.mark = MK_FREE;
                wr_data.lf   = half_val;
            end
            OP_A_STEP: begin
                rd_en   = 1'b1;
                rd_addr = go_left ? left_idx : right_idx;
            end
            OP_A_FINAL: begin
                if (r_node.mark == MK_FREE) begin
                    wr_en         = 1'b1;
                    wr_data.mark  = MK_ALLOC;
                    wr_data.owner = r_id;
                end
            end
            OP_U_RDL: begin
                rd_en   = 1'b1;
                rd_addr = IDX_W'({parent_idx, 1'b1});
            end
            OP_U_RDR: begin
                rd_en   = 1'b1;
                rd_addr = right_idx;
            end
            OP_U_EVAL: begin
                wr_en = 1'b1;
                if (both_free) begin
                    wr_addr = left_idx;
                end else begin
                    wr_data.mark = MK_SPLIT;
                    wr_data.lf   = (r_left.lf > r_rd.lf) ? r_left.lf : r_rd.lf;
                end
            end
            OP_U_WR: begin
                wr_en   = 1'b1;
                wr_addr = right_idx;
            end
            OP_U_WP: begin
                wr_en        = 1'b1;
                wr_data.mark = MK_FREE;
                wr_data.lf   = size_val;
            end
            OP_F_EVAL: begin
                if (hit) begin
                    wr_en        = 1'b1;
                    wr_data.mark = MK_FREE;
                    wr_data.lf   = size_val;
                end else if (descend) begin
                    rd_en   = 1'b1;
                    rd_addr = left_idx;
                end
            end
            OP_F_UP: begin
                if (r_idx != '0 && r_idx[0]) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + IDX_W'(1);
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd <= r_mem[rd_addr];
    end

    // Control and configuration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsz       <= TOTAL_LOG2_RESET;
            r_min       <= MIN_LOG2_RESET;
            r_used      <= '0;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            if (i_op == OP_DONE && out_free) r_out_valid <= 1'b1;
            if (i_op == OP_CLR) r_clr_cnt <= r_clr_cnt + IDX_W'(1);
            if (i_op == OP_A_FINAL && r_node.mark == MK_FREE) begin
                r_used <= r_used + q_val[BYTES_W-1:0];
            end
            if (i_op == OP_F_EVAL && hit) begin
                r_used <= (r_used >= size_val) ? r_used - size_val : '0;
            end
            if (cfg_wr) begin
                if (t_reg'(paddr[2]) == REG_TOTAL_LOG2) begin
                    r_tsz     <= pwdata[LOG_W-1:0];
                    r_used    <= '0;
                    r_clr_cnt <= '0;
                end else begin
                    r_min <= pwdata[LOG_W-1:0];
                end
            end
        end
    end

    // Walk registers and results
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_id    <= i_owner_id;
                r_qlog  <= qlog_in;
                r_idx   <= '0;
                r_depth <= '0;
                r_lvl   <= tlog;
                r_start <= BYTES_W'(1);
            end
            OP_A_CHK: begin
                r_node      <= r_rd;
                r_res_start <= '0;
                r_res_bytes <= '0;
                priority if (too_large) r_res_status <= ST_TOO_LARGE;
                else if (over_cap) r_res_status <= ST_OVER_CAP;
                else if (no_hole) r_res_status <= ST_NO_HOLE;
                else r_res_status <= ST_OK;
            end
            OP_A_EVAL: begin
                r_lf_l <= (r_node.mark == MK_FREE) ? half_val : r_rd.lf;
            end
            OP_A_STEP: begin
                r_idx   <= go_left ? left_idx : right_idx;
                r_lvl   <= r_lvl - LOG_W'(1);
                r_depth <= r_depth + LOG_W'(1);
                if (!go_left) r_start <= r_start + half_val;
            end
            OP_A_LOAD: begin
                r_node <= r_rd;
            end
            OP_A_FINAL: begin
                if (r_node.mark == MK_FREE) begin
                    r_res_status <= ST_OK;
                    r_res_start  <= r_start;
                    r_res_bytes  <= q_val[BYTES_W-1:0];
                end else begin
                    r_res_status <= ST_NO_HOLE;
                end
            end
            OP_U_RDL: begin
                r_idx   <= parent_idx;
                r_lvl   <= r_lvl + LOG_W'(1);
                r_depth <= r_depth - LOG_W'(1);
            end
            OP_U_RDR: begin
                r_left <= r_rd;
            end
            OP_F_EVAL: begin
                if (hit) begin
                    r_res_status <= ST_OK;
                    r_res_start  <= (BYTES_W'(pos) << r_lvl) + BYTES_W'(1);
                    r_res_bytes  <= size_val;
                end else if (descend) begin
                    r_idx   <= left_idx;
                    r_lvl   <= r_lvl - LOG_W'(1);
                    r_depth <= r_depth + LOG_W'(1);
                end
            end
            OP_F_UP: begin
                priority if (r_idx == '0) begin
                    r_res_status <= ST_NOT_FOUND;
                    r_res_start  <= '0;
                    r_res_bytes  <= '0;
                end else if (r_idx[0]) begin
                    r_idx <= r_idx + IDX_W'(1);
                end else begin
                    r_idx   <= parent_idx;
                    r_lvl   <= r_lvl + LOG_W'(1);
                    r_depth <= r_depth - LOG_W'(1);
                end
            end
            OP_DONE: begin
                if (out_free) begin
                    r_o_status <= r_res_status;
                    r_o_start  <= r_res_start;
                    r_o_bytes  <= r_res_bytes;
                    r_o_used   <= r_used;
                end
            end
            default: begin
                r_lf_l <= r_lf_l;
            end
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_o_status;
    assign o_start_addr  = r_o_start;
    assign o_block_bytes = r_o_bytes;
    assign o_used_bytes  = r_o_used;

    a_used_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_used} <= total_val)
        else $error("allocated byte count exceeds the managed size");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_status != ST_OK) |-> (r_o_start == '0 && r_o_bytes == '0))
        else $error("failed request reports a block");

    a_ok_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_status == ST_OK) |-> $onehot(r_o_bytes))
        else $error("granted block size is not a power of two");

endmodule

>>> design/buddy_allocator.sv
// Top level of the buddy allocator: joins the controller and the datapath.
// Depends on balloc_pkg, balloc_ctrl and balloc_dp.
//
// Binary buddy allocator over 2^total_size_log2 bytes, one request at a time,
// one result beat per request beat. After reset, and after every write of
// total_size_log2, the node memory is swept, and no request is taken during
// the sweep. All tree state lives in one single-port node memory with
// a registered read, so time is set by memory accesses. An allocate that
// fails the size, capacity or free-space check is refused before any descent.
// A granted allocate descends from the root, splitting free nodes on its way,
// then marks the block and walks back to the root, updating each parent.
// A free scans the tree in preorder, climbing back where a subtree holds no
// match, then walks to the root, merging free buddies. The result register lets
// the next request in while a result beat still waits.
module buddy_allocator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_func,
    input  logic [balloc_pkg::ID_BITS-1:0]       i_owner_id,
    input  logic [balloc_pkg::REQ_W-1:0]         i_request_bytes,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [balloc_pkg::STATUS_W-1:0]      o_status,
    output logic [balloc_pkg::BYTES_W-1:0]       o_start_addr,
    output logic [balloc_pkg::BYTES_W-1:0]       o_block_bytes,
    output logic [balloc_pkg::BYTES_W-1:0]       o_used_bytes,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [balloc_pkg::ADDR_W-1:0]        paddr,
    input  logic [balloc_pkg::DATA_W-1:0]        pwdata,
    output logic [balloc_pkg::DATA_W-1:0]        prdata,
    output logic                                 pready
);
    import balloc_pkg::*;

    t_op    op;
    t_flags flags;

    balloc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .i_flags (flags),
        .o_stall (o_stall),
        .o_op    (op)
    );

    balloc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .o_flags         (flags),
        .i_owner_id      (i_owner_id),
        .i_request_bytes (i_request_bytes),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_start_addr    (o_start_addr),
        .o_block_bytes   (o_block_bytes),
        .o_used_bytes    (o_used_bytes),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

endmodule

>>> verif/buddy_allocator_test.sv
// Self-checking testbench for the buddy allocator: drives allocate and free
// beats, predicts every result beat and compares it. Depends on balloc_pkg and buddy_allocator.
`timescale 1ns / 1ps

module buddy_allocator_test;
    import balloc_pkg::*;

    localparam int LIMIT_CYCLES = 15_000_000;

    typedef struct {
        t_status            status;
        logic [BYTES_W-1:0] start_addr;
        logic [BYTES_W-1:0] block_bytes;
        logic [BYTES_W-1:0] used_bytes;
    } t_answer;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_func = 1'b0;
    logic [ID_BITS-1:0]   i_owner_id = '0;
    logic [REQ_W-1:0]     i_request_bytes = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [BYTES_W-1:0]   o_start_addr;
    logic [BYTES_W-1:0]   o_block_bytes;
    logic [BYTES_W-1:0]   o_used_bytes;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    buddy_allocator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_owner_id(i_owner_id), .i_request_bytes(i_request_bytes),
        .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
        .o_start_addr(o_start_addr), .o_block_bytes(o_block_bytes),
        .o_used_bytes(o_used_bytes), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    // Shadow copy of the allocator tree.
    t_mark         tree_mark  [NODE_COUNT];
    int unsigned   tree_free  [NODE_COUNT];
    logic [15:0]   tree_owner [NODE_COUNT];
    int unsigned   used_space;
    logic [3:0]    size_log2_reg;
    logic [3:0]    min_log2_reg;

    t_answer       pending_answers[$];
    logic [15:0]   live_owners[$];
    int            error_count = 0;
    int            cycle_count = 0;
    bit            quiet = 1'b0;
    bit            hold_request = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int unsigned eff_size_log2();
        if (size_log2_reg < 1) return 1;
        if (size_log2_reg > MAX_SIZE_LOG2) return MAX_SIZE_LOG2;
        return int'(size_log2_reg);
    endfunction

    function automatic void clear_tree();
        for (int i = 0; i < NODE_COUNT; i++) begin
            tree_mark[i] = MK_ABSENT;
            tree_free[i] = 0;
            tree_owner[i] = '0;
        end
        tree_mark[0] = MK_FREE;
        tree_free[0] = 1 << eff_size_log2();
        used_space = 0;
    endfunction

    // Climb to the root, joining buddies that are both free.
    function automatic void merge_upward(int unsigned idx, int unsigned depth, int unsigned t);
        int unsigned p, l, r;
        while (idx > 0 && depth > 0) begin
            p = (idx - 1) >> 1;
            l = 2 * p + 1;
            r = l + 1;
            depth--;
            if (tree_mark[l] == MK_FREE && tree_mark[r] == MK_FREE) begin
                tree_mark[l] = MK_ABSENT;
                tree_mark[r] = MK_ABSENT;
                tree_free[l] = 0;
                tree_free[r] = 0;
                tree_mark[p] = MK_FREE;
                tree_free[p] = 1 << (t - depth);
            end else begin
                tree_mark[p] = MK_SPLIT;
                tree_free[p] = (tree_free[l] > tree_free[r]) ? tree_free[l] : tree_free[r];
            end
            idx = p;
        end
    endfunction

    function automatic int find_block(int unsigned idx, int unsigned depth,
                                      int unsigned t, logic [15:0] id);
        int hit;
        if (idx >= NODE_COUNT) return -1;
        if (tree_mark[idx] == MK_ALLOC && tree_owner[idx] == id) return idx;
        if (tree_mark[idx] != MK_SPLIT || depth + 1 >= t) return -1;
        hit = find_block(2 * idx + 1, depth + 1, t, id);
        if (hit >= 0) return hit;
        return find_block(2 * idx + 2, depth + 1, t, id);
    endfunction

    function automatic t_answer serve_request(bit fn, logic [15:0] id, logic [10:0] req);
        t_answer     a;
        int unsigned t, total, q, idx, depth, size, s, half, l, pos;
        int          hit;
        t = eff_size_log2();
        total = 1 << t;
        a.status = ST_OK;
        a.start_addr = '0;
        a.block_bytes = '0;
        if (!fn) begin
            q = 2;
            while (q < req) q = q << 1;
            if (q < (1 << min_log2_reg)) q = 1 << min_log2_reg;
            if (q > total) a.status = ST_TOO_LARGE;
            else if (used_space + q > total) a.status = ST_OVER_CAP;
            else if (tree_free[0] < q) a.status = ST_NO_HOLE;
            else begin
                idx = 0; depth = 0; size = total; s = 1;
                while (size > q && idx < NODE_COUNT) begin
                    half = size >> 1;
                    l = 2 * idx + 1;
                    if (l + 1 >= NODE_COUNT) break;
                    if (tree_mark[idx] == MK_FREE) begin
                        tree_mark[idx] = MK_SPLIT;
                        tree_mark[l] = MK_FREE;
                        tree_mark[l+1] = MK_FREE;
                        tree_free[l] = half;
                        tree_free[l+1] = half;
                        tree_owner[l] = '0;
                        tree_owner[l+1] = '0;
                    end
                    if (tree_free[l] >= q) idx = l;
                    else begin
                        idx = l + 1;
                        s += half;
                    end
                    size = half;
                    depth++;
                end
                if (size == q && idx < NODE_COUNT && tree_mark[idx] == MK_FREE) begin
                    tree_mark[idx] = MK_ALLOC;
                    tree_owner[idx] = id;
                    tree_free[idx] = 0;
                    merge_upward(idx, depth, t);
                    used_space += q;
                    a.start_addr = BYTES_W'(s);
                    a.block_bytes = BYTES_W'(q);
                end else begin
                    a.status = ST_NO_HOLE;
                end
            end
        end else begin
            hit = find_block(0, 0, t, id);
            if (hit < 0) a.status = ST_NOT_FOUND;
            else begin
                idx = hit;
                depth = 0;
                while (((idx + 1) >> (depth + 1)) != 0) depth++;
                pos = idx + 1 - (1 << depth);
                size = 1 << (t - depth);
                tree_mark[idx] = MK_FREE;
                tree_owner[idx] = '0;
                tree_free[idx] = size;
                merge_upward(idx, depth, t);
                used_space = (used_space >= size) ? used_space - size : 0;
                a.start_addr = BYTES_W'(pos * size + 1);
                a.block_bytes = BYTES_W'(size);
            end
        end
        a.used_bytes = BYTES_W'(used_space);
        return a;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch at cycle %0d: %s got %0d, expected %0d",
                 cycle_count, field, got, want);
        error_count++;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_answer exp_a;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                exp_a = pending_answers.pop_front();
                if (o_status !== exp_a.status)
                    report_mismatch("status", int'(o_status), int'(exp_a.status));
                if (o_start_addr !== exp_a.start_addr)
                    report_mismatch("start_addr", int'(o_start_addr),
                                    int'(exp_a.start_addr));
                if (o_block_bytes !== exp_a.block_bytes)
                    report_mismatch("block_bytes", int'(o_block_bytes),
                                    int'(exp_a.block_bytes));
                if (o_used_bytes !== exp_a.used_bytes)
                    report_mismatch("used_bytes", int'(o_used_bytes),
                                    int'(exp_a.used_bytes));
            end
        end
    end

    // Receiver: random stall bursts, and one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_request = 1'b0;
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic wait_drained();
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(t_reg r, logic [3:0] value);
        i_valid <= 1'b0;
        wait_drained();
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * int'(r));
        pwdata <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (r == REG_TOTAL_LOG2) begin
            size_log2_reg = value;
            clear_tree();
        end else begin
            min_log2_reg = value;
        end
    endtask

    // Offer one request beat, wait for it to be taken, then predict it.
    task automatic send_request(bit fn, logic [15:0] id, logic [10:0] req);
        t_answer a;
        int      k;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_owner_id <= id;
        i_request_bytes <= req;
        do @(posedge i_clk); while (o_stall);
        a = serve_request(fn, id, req);
        pending_answers.push_back(a);
        if (a.status == ST_OK) begin
            if (!fn) live_owners.push_back(id);
            else begin
                for (k = 0; k < live_owners.size(); k++) begin
                    if (live_owners[k] == id) begin
                        live_owners.delete(k);
                        break;
                    end
                end
            end
        end
    endtask

    task automatic test_directed();
        send_request(1'b0, 16'd1, 11'd0);
        send_request(1'b0, 16'hFFFF, 11'd1024);    // over capacity
        send_request(1'b0, 16'd5, 11'h7FF);        // too large
        send_request(1'b0, 16'd0, 11'd3);
        send_request(1'b1, 16'd0, 11'd0);
        send_request(1'b1, 16'd1234, 11'h7FF);     // unknown owner
        send_request(1'b0, 16'd7, 11'd100);
        send_request(1'b0, 16'd7, 11'd1);          // same owner twice
        send_request(1'b1, 16'd7, 11'd0);
        send_request(1'b1, 16'd7, 11'd0);
        send_request(1'b1, 16'd1, 11'd0);
        // Fragment the memory so that a half-size block finds no hole.
        for (int i = 0; i < 4; i++) send_request(1'b0, 16'(10 + i), 11'd256);
        send_request(1'b1, 16'd10, 11'd0);
        send_request(1'b1, 16'd12, 11'd0);
        send_request(1'b0, 16'd20, 11'd512);
        send_request(1'b0, 16'hAAAA, 11'h555);
        send_request(1'b1, 16'd11, 11'd0);
        send_request(1'b1, 16'd13, 11'd0);
        send_request(1'b0, 16'h5555, 11'd1024);
        send_request(1'b1, 16'h5555, 11'h2AA);
        write_register(REG_TOTAL_LOG2, 4'd0);      // acts as a two-byte memory
        write_register(REG_MIN_LOG2, 4'd0);
        send_request(1'b0, 16'd3, 11'd0);
        send_request(1'b0, 16'd4, 11'd1);
        write_register(REG_MIN_LOG2, 4'd15);       // minimum above any memory
        send_request(1'b0, 16'd3, 11'd1);
    endtask

    task automatic random_request(int unsigned t);
        int unsigned pick;
        logic [15:0] id;
        logic [10:0] req;
        pick = $urandom_range(0, 99);
        if (pick < 40 && live_owners.size() > 0) begin
            send_request(1'b1, live_owners[$urandom_range(0, live_owners.size() - 1)],
                         11'($urandom));
        end else if (pick < 46) begin
            send_request(1'b1, 16'($urandom), 11'($urandom));
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 80) id = 16'($urandom_range(1, 30));
            else if (pick < 95) id = 16'($urandom);
            else id = (pick < 97) ? 16'd0 : 16'hFFFF;
            if ($urandom_range(0, 29) == 0) req = 11'($urandom);
            else req = 11'($urandom_range(0, 1 << $urandom_range(0, (t > 2) ? t - 2 : 0)));
            send_request(1'b0, id, req);
        end
    endtask

    task automatic test_random_phase(logic [3:0] size_log2, logic [3:0] min_log2, int count);
        write_register(REG_TOTAL_LOG2, size_log2);
        write_register(REG_MIN_LOG2, min_log2);
        live_owners.delete();
        repeat (count) random_request(eff_size_log2());
    endtask

    task automatic test_backpressure();
        write_register(REG_TOTAL_LOG2, 4'd6);
        write_register(REG_MIN_LOG2, 4'd1);
        live_owners.delete();
        hold_request = 1'b1;
        repeat (8) random_request(6);
        // Sender waits for every result before going on.
        i_valid <= 1'b0;
        wait_drained();
        repeat (8) random_request(6);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        size_log2_reg = TOTAL_LOG2_RESET;
        min_log2_reg = MIN_LOG2_RESET;
        clear_tree();
        test_directed();
        test_random_phase(4'd10, 4'd1, 150);
        test_random_phase(4'd4, 4'd1, 110);
        test_random_phase(4'd6, 4'd3, 110);
        test_random_phase(4'd1, 4'd0, 50);
        test_backpressure();
        test_random_phase(4'd15, 4'd2, 140);
        test_random_phase(4'd8, 4'd11, 30);
        test_random_phase(4'd10, 4'd0, 120);
        quiet = 1'b1;
        test_random_phase(4'd10, 4'd1, 180);
        i_valid <= 1'b0;
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
design/balloc_pkg.sv
design/balloc_ctrl.sv
design/balloc_dp.sv
design/buddy_allocator.sv
verif/buddy_allocator_test.sv
